// File: rtl/core/tbpc_pkg.sv
// types and constants shared by the touch button press classifier
package tbpc_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] REG_BUTTON_ID   = 2'd0;
  localparam logic [1:0] REG_SINGLE_MODE = 2'd1;
  localparam logic [1:0] REG_MIN_PRESS   = 2'd2;

  localparam logic [7:0]  BUTTON_ID_RST = 8'd1;
  localparam logic [15:0] MIN_PRESS_RST = 16'd100;

  // event codes
  localparam logic [2:0] EV_NONE          = 3'd0;
  localparam logic [2:0] EV_INITIAL       = 3'd1;
  localparam logic [2:0] EV_SHORT_HOLDING = 3'd2;
  localparam logic [2:0] EV_LONG_HOLDING  = 3'd3;
  localparam logic [2:0] EV_SHORT_RELEASE = 3'd4;
  localparam logic [2:0] EV_LONG_RELEASE  = 3'd5;

  // repeat intervals, ms
  localparam logic [12:0] IVL_RELEASED = 13'd5000;
  localparam logic [12:0] IVL_START    = 13'd250;
  localparam logic [12:0] IVL_SINGLE   = 13'd50;
  localparam logic [12:0] IVL_1S       = 13'd150;
  localparam logic [12:0] IVL_2S       = 13'd100;
  localparam logic [12:0] IVL_3S       = 13'd50;
  localparam logic [12:0] IVL_4S       = 13'd10;

  // hold thresholds, ms
  localparam logic [31:0] HOLD_1S = 32'd1000;
  localparam logic [31:0] HOLD_2S = 32'd2000;
  localparam logic [31:0] HOLD_3S = 32'd3000;
  localparam logic [31:0] HOLD_4S = 32'd4000;

  typedef struct packed {
    logic [7:0]  button_id;
    logic        single_press_mode;
    logic [15:0] min_press_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  touch_tag;
    logic [31:0] now_ms;
    logic        handler_reset;
  } sample_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       is_pressed;
    logic       early_touch;
    logic       alt_highlight;
  } result_t;

endpackage

// File: rtl/core/tbpc_chan.sv
// valid/ready channel interface carrying one payload per transaction
interface tbpc_chan #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/tbpc_regs.sv
// apb configuration registers
module tbpc_regs
  import tbpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_id         <= BUTTON_ID_RST;
      cfg.single_press_mode <= 1'b0;
      cfg.min_press_ms      <= MIN_PRESS_RST;
    end else if (wr) begin
      case (idx)
        REG_BUTTON_ID:   cfg.button_id         <= pwdata[7:0];
        REG_SINGLE_MODE: cfg.single_press_mode <= pwdata[0];
        REG_MIN_PRESS:   cfg.min_press_ms      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BUTTON_ID:   prdata = {24'd0, cfg.button_id};
      REG_SINGLE_MODE: prdata = {31'd0, cfg.single_press_mode};
      REG_MIN_PRESS:   prdata = {16'd0, cfg.min_press_ms};
      default:         prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/tbpc_core.sv
// press state and per-sample classification logic
module tbpc_core
  import tbpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step,
  input  sample_t smp,
  output result_t res
);

  logic        held, held_next;
  logic        owned, owned_next;
  logic [31:0] press_start, press_start_next;
  logic [31:0] repeat_mark, repeat_mark_next;
  logic [12:0] repeat_interval, repeat_interval_next;
  logic        long_seen, long_seen_next;
  logic        await_release, await_release_next;
  logic        blink_phase, blink_phase_next;

  logic        hit, rel;
  logic        mark_due, past1, past2, past3, past4;
  logic        early_rel;
  logic [31:0] min_ext;
  logic [31:0] mark_due_at;
  logic [2:0]  ev;

  assign min_ext     = {16'd0, cfg.min_press_ms};
  assign mark_due_at = repeat_mark + {19'd0, repeat_interval};
  assign mark_due    = smp.now_ms > mark_due_at;
  assign past1       = smp.now_ms > (press_start + HOLD_1S);
  assign past2       = smp.now_ms > (press_start + HOLD_2S);
  assign past3       = smp.now_ms > (press_start + HOLD_3S);
  assign past4       = smp.now_ms > (press_start + HOLD_4S);
  assign early_rel   = (press_start + min_ext) > smp.now_ms;

  assign hit = (smp.touch_tag == cfg.button_id);
  assign rel = !hit && (smp.touch_tag == 8'd0) && owned;

  always_comb begin
    held_next            = held;
    owned_next           = owned;
    press_start_next     = press_start;
    repeat_mark_next     = repeat_mark;
    repeat_interval_next = repeat_interval;
    long_seen_next       = long_seen;
    await_release_next   = await_release;
    blink_phase_next     = blink_phase;
    ev                   = EV_NONE;

    if (hit) begin
      if (!held) begin
        blink_phase_next     = 1'b0;
        ev                   = EV_INITIAL;
        repeat_interval_next = cfg.single_press_mode ? IVL_SINGLE : IVL_START;
        if (cfg.single_press_mode && smp.handler_reset) begin
          owned_next       = 1'b0;
          press_start_next = '0;
        end else begin
          long_seen_next   = 1'b0;
          held_next        = 1'b1;
          owned_next       = 1'b1;
          press_start_next = smp.now_ms;
          repeat_mark_next = smp.now_ms;
        end
      end else if (mark_due) begin
        repeat_mark_next = smp.now_ms;
        if (!cfg.single_press_mode) begin
          blink_phase_next = !blink_phase;
          ev               = EV_SHORT_HOLDING;
          if (past4)      repeat_interval_next = IVL_4S;
          else if (past3) repeat_interval_next = IVL_3S;
          else if (past2) repeat_interval_next = IVL_2S;
          else if (past1) repeat_interval_next = IVL_1S;
        end else if (past1 && !await_release) begin
          long_seen_next     = 1'b1;
          ev                 = EV_LONG_HOLDING;
          await_release_next = 1'b1;
        end
      end
    end else if (rel) begin
      await_release_next = 1'b0;
      if (held) begin
        // a touch released too early is dropped without an event
        if (early_rel || !cfg.single_press_mode) begin
          repeat_interval_next = IVL_RELEASED;
        end else begin
          ev             = long_seen ? EV_LONG_RELEASE : EV_SHORT_RELEASE;
          long_seen_next = 1'b0;
        end
      end
      held_next        = 1'b0;
      press_start_next = '0;
      repeat_mark_next = '0;
    end

    res.event_code    = ev;
    res.is_pressed    = held_next;
    res.early_touch   = held_next && ((press_start_next + min_ext) > smp.now_ms);
    res.alt_highlight = blink_phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held            <= 1'b0;
      owned           <= 1'b0;
      press_start     <= '0;
      repeat_mark     <= '0;
      repeat_interval <= '0;
      long_seen       <= 1'b0;
      await_release   <= 1'b0;
      blink_phase     <= 1'b0;
    end else if (step) begin
      held            <= held_next;
      owned           <= owned_next;
      press_start     <= press_start_next;
      repeat_mark     <= repeat_mark_next;
      repeat_interval <= repeat_interval_next;
      long_seen       <= long_seen_next;
      await_release   <= await_release_next;
      blink_phase     <= blink_phase_next;
    end
  end

  a_held_owned: assert property (@(posedge clk) disable iff (rst) held |-> owned)
    else $error("button held without ownership");

  a_await_held: assert property (@(posedge clk) disable iff (rst)
    await_release |-> (held && long_seen))
    else $error("waiting for release while not in a long hold");

  a_release_drops: assert property (@(posedge clk) disable iff (rst)
    (step && rel) |=> !held && !await_release && (press_start == 32'd0))
    else $error("release sample left press state behind");

endmodule

// File: rtl/core/touch_button_press_classifier.sv
// touch button press classifier top level: input stage, classifier, result stage
// pipeline: a sample is registered in the input stage, its result then in the result stage
// throughput: one sample per cycle while the result sink does not stall
// the input stage stalls while the result stage is full and not being emptied; a new
// sample is taken while an earlier result waits for the sink only if the input stage is empty
// reset: synchronous, clears both stages, the press state and the registers
module touch_button_press_classifier
  import tbpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  tbpc_chan.sink            sample,
  tbpc_chan.source          result
);

  cfg_t    cfg;
  sample_t s_data;
  logic    s_valid;
  result_t r_data;
  logic    r_valid;
  result_t core_res;
  logic    advance;
  logic    take;

  tbpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbpc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .smp  (s_data),
    .res  (core_res)
  );

  // the sample stage moves on whenever the result stage is free or being emptied
  assign advance      = s_valid && (!r_valid || result.ready);
  assign sample.ready = !s_valid || advance;
  assign take         = sample.valid && sample.ready;

  assign result.valid   = r_valid;
  assign result.payload = r_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      s_valid <= take || (s_valid && !advance);
      r_valid <= advance || (r_valid && !result.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_data <= sample.payload;
    end
    if (advance) begin
      r_data <= core_res;
    end
  end

endmodule

// File: sim/testbench.sv
// self-checking testbench for the touch button press classifier
`timescale 1ns / 100ps

module testbench;
  import tbpc_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned PHASE_ITEMS = 180;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  tbpc_chan #(.T(sample_t)) touch_ch ();
  tbpc_chan #(.T(result_t)) event_ch ();

  touch_button_press_classifier uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample(touch_ch),
    .result(event_ch)
  );

  sample_t touches_to_send[$];
  result_t expected_outcomes[$];
  int unsigned fail_count = 0;
  int unsigned phase_count;
  logic [31:0] now_cur;

  // predictor copy of the registers and the press state
  logic [7:0] cfg_id;
  logic cfg_single;
  logic [15:0] cfg_min;
  logic btn_down;
  logic btn_claimed;
  logic [31:0] down_at;
  logic [31:0] last_repeat_at;
  logic [12:0] repeat_gap;
  logic long_reported;
  logic hold_latched;
  logic blink_now;

  always #5 clk = ~clk;

  function automatic result_t classify_sample(sample_t s);
    result_t r;
    logic [31:0] due;
    logic [31:0] early_end;
    r.event_code = EV_NONE;
    if (s.touch_tag == cfg_id) begin
      due = last_repeat_at + {19'd0, repeat_gap};
      if (!btn_down) begin
        blink_now = 1'b0;
        r.event_code = EV_INITIAL;
        repeat_gap = cfg_single ? IVL_SINGLE : IVL_START;
        if (cfg_single && s.handler_reset) begin
          btn_down = 1'b0;
          btn_claimed = 1'b0;
          down_at = '0;
        end else begin
          long_reported = 1'b0;
          btn_down = 1'b1;
          btn_claimed = 1'b1;
          down_at = s.now_ms;
          last_repeat_at = s.now_ms;
        end
      end else if (s.now_ms > due) begin
        last_repeat_at = s.now_ms;
        if (!cfg_single) begin
          blink_now = ~blink_now;
          r.event_code = EV_SHORT_HOLDING;
          if (s.now_ms > down_at + HOLD_4S) repeat_gap = IVL_4S;
          else if (s.now_ms > down_at + HOLD_3S) repeat_gap = IVL_3S;
          else if (s.now_ms > down_at + HOLD_2S) repeat_gap = IVL_2S;
          else if (s.now_ms > down_at + HOLD_1S) repeat_gap = IVL_1S;
        end else if (s.now_ms > down_at + HOLD_1S && !hold_latched) begin
          long_reported = 1'b1;
          r.event_code = EV_LONG_HOLDING;
          hold_latched = 1'b1;
        end
      end
    end else if (s.touch_tag == 8'd0 && btn_claimed) begin
      early_end = down_at + {16'd0, cfg_min};
      // a touch that ends too early is dropped without an event
      if (btn_down && early_end > s.now_ms) begin
        btn_down = 1'b0;
        repeat_gap = IVL_RELEASED;
      end
      hold_latched = 1'b0;
      if (btn_down && cfg_single) begin
        btn_down = 1'b0;
        r.event_code = long_reported ? EV_LONG_RELEASE : EV_SHORT_RELEASE;
        long_reported = 1'b0;
      end else if (btn_down) begin
        btn_down = 1'b0;
        repeat_gap = IVL_RELEASED;
      end
      down_at = '0;
      last_repeat_at = '0;
    end
    early_end = down_at + {16'd0, cfg_min};
    r.is_pressed = btn_down;
    r.early_touch = btn_down && (early_end > s.now_ms);
    r.alt_highlight = blink_now;
    return r;
  endfunction

  function automatic logic [31:0] hold_step();
    case ($urandom_range(0, 19))
      0, 1: return 32'd0;
      2, 3: return $urandom_range(1, 12);
      4, 5: return $urandom_range(900, 1500);
      6: return $urandom();
      default: return $urandom_range(5, 300);
    endcase
  endfunction

  task automatic queue_touch(input logic [7:0] tag, input logic [31:0] dt_ms,
                             input logic hreset);
    sample_t s;
    now_cur = now_cur + dt_ms;
    s.touch_tag = tag;
    s.now_ms = now_cur;
    s.handler_reset = hreset;
    touches_to_send.push_back(s);
    phase_count++;
  endtask

  // press of this button with random timing and occasional foreign touches, ended by releases
  task automatic queue_press_sequence();
    int holds;
    if ($urandom_range(0, 9) == 0) now_cur = $urandom();
    repeat ($urandom_range(0, 1))
      queue_touch(8'($urandom_range(1, 255)), $urandom_range(0, 300),
                  1'($urandom_range(0, 1)));
    holds = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    repeat (holds) begin
      if ($urandom_range(0, 11) == 0)
        queue_touch(8'($urandom_range(0, 255)), hold_step(), 1'($urandom_range(0, 1)));
      else
        queue_touch(cfg_id, hold_step(), $urandom_range(0, 3) == 0);
    end
    repeat ($urandom_range(1, 3))
      queue_touch(8'd0, $urandom_range(0, 150), 1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    while (touches_to_send.size() != 0 || touch_ch.valid || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_BUTTON_ID: cfg_id = value[7:0];
      REG_SINGLE_MODE: cfg_single = value[0];
      REG_MIN_PRESS: cfg_min = value[15:0];
      default: ;
    endcase
  endtask

  // upper data bits carry junk, the block must ignore them
  task automatic configure(input logic [7:0] id, input logic single, input logic [15:0] min_ms);
    logic [31:0] junk;
    settle();
    junk = $urandom();
    write_register(REG_BUTTON_ID, {junk[31:8], id});
    junk = $urandom();
    write_register(REG_SINGLE_MODE, {junk[31:1], single});
    junk = $urandom();
    write_register(REG_MIN_PRESS, {junk[31:16], min_ms});
    @(negedge clk);
    phase_count = 0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin : stimulus
    logic [7:0] id;
    logic single;
    logic [15:0] min_ms;
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    touch_ch.valid = 1'b0;
    touch_ch.payload = '0;
    event_ch.ready = 1'b0;
    cfg_id = BUTTON_ID_RST;
    cfg_single = 1'b0;
    cfg_min = MIN_PRESS_RST;
    btn_down = 1'b0;
    btn_claimed = 1'b0;
    down_at = '0;
    last_repeat_at = '0;
    repeat_gap = '0;
    long_reported = 1'b0;
    hold_latched = 1'b0;
    blink_now = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // auto-repeat mode from reset: release with no owner, foreign tags,
    // the full interval ladder, repeated releases, a touch that is too short
    now_cur = 32'd1000;
    queue_touch(8'd0, 0, 1'b0);
    queue_touch(8'd7, 10, 1'b1);
    queue_touch(8'd1, 10, 1'b0);
    queue_touch(8'd1, 50, 1'b0);
    queue_touch(8'd1, 251, 1'b0);
    queue_touch(8'd255, 5, 1'b0);
    queue_touch(8'd1, 900, 1'b0);
    queue_touch(8'd1, 1000, 1'b0);
    queue_touch(8'd1, 1000, 1'b0);
    queue_touch(8'd1, 1000, 1'b0);
    queue_touch(8'd1, 11, 1'b0);
    queue_touch(8'd0, 5, 1'b0);
    queue_touch(8'd0, 5, 1'b0);
    queue_touch(8'd1, 100, 1'b0);
    queue_touch(8'd0, 40, 1'b1);
    // left held across the mode change
    queue_touch(8'd1, 20, 1'b0);

    configure(8'd1, 1'b1, 16'd100);
    queue_touch(8'd1, 1200, 1'b0);
    queue_touch(8'd0, 10, 1'b0);
    queue_touch(8'd1, 10, 1'b1);
    queue_touch(8'd1, 10, 1'b0);
    queue_touch(8'd1, 1, 1'b1);
    queue_touch(8'd0, 300, 1'b0);
    // hold across the timestamp wrap
    now_cur = 32'hFFFF_FC00;
    queue_touch(8'd1, 0, 1'b0);
    queue_touch(8'd1, 1500, 1'b0);
    queue_touch(8'd0, 10, 1'b0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin id = 8'd1; single = 1'b0; min_ms = 16'd100; end
        1: begin id = 8'd255; single = 1'b1; min_ms = 16'd0; end
        2: begin id = 8'($urandom_range(2, 254)); single = 1'b0; min_ms = 16'hFFFF; end
        3: begin
          id = 8'($urandom_range(2, 254));
          single = 1'b1;
          min_ms = 16'($urandom_range(50, 400));
        end
        4: begin id = 8'd255; single = 1'b0; min_ms = 16'd0; end
        5: begin id = 8'd0; single = 1'($urandom_range(0, 1)); min_ms = 16'd100; end
        6: begin
          id = 8'($urandom_range(2, 254));
          single = 1'b0;
          min_ms = 16'($urandom_range(1, 1000));
        end
        default: begin id = 8'($urandom_range(2, 254)); single = 1'b1; min_ms = 16'hFFFF; end
      endcase
      configure(id, single, min_ms);
      while (phase_count < PHASE_ITEMS) queue_press_sequence();
    end

    settle();
    if (fail_count == 0 && expected_outcomes.size() == 0) begin
      $display("touch_button_press_classifier verification clean");
    end else begin
      $display("touch_button_press_classifier verification failed");
    end
    $finish;
  end

  // sender: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      touch_ch.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (touch_ch.valid && touch_ch.ready)
        expected_outcomes.push_back(classify_sample(touch_ch.payload));
      if (touch_ch.valid && !touch_ch.ready) begin
        // offer stays up until the transaction completes
      end else if (gap_left != 0) begin
        touch_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (touches_to_send.size() != 0) begin
        touch_ch.valid <= 1'b1;
        touch_ch.payload <= touches_to_send.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        touch_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked anew each time the mode timer wraps, plus one long hold-off
  logic [5:0] mode_timer;
  logic [1:0] stall_mode;
  int unsigned hold_off;
  int unsigned events_taken;
  logic hold_done;

  always @(posedge clk) begin
    if (rst) begin
      event_ch.ready <= 1'b0;
      mode_timer <= '0;
      stall_mode <= '0;
      hold_off <= 0;
      events_taken <= 0;
      hold_done <= 1'b0;
    end else begin
      if (event_ch.valid && event_ch.ready) events_taken <= events_taken + 1;
      mode_timer <= mode_timer + 6'd1;
      if (mode_timer == 6'd63) stall_mode <= 2'($urandom_range(0, 3));
      if (hold_off != 0) begin
        event_ch.ready <= 1'b0;
        hold_off <= hold_off - 1;
      end else if (!hold_done && events_taken >= 300) begin
        event_ch.ready <= 1'b0;
        hold_off <= LONG_HOLD;
        hold_done <= 1'b1;
      end else begin
        case (stall_mode)
          2'd0: event_ch.ready <= 1'b1;
          2'd1: event_ch.ready <= 1'($urandom_range(0, 1));
          2'd2: event_ch.ready <= (mode_timer[1:0] == 2'd0);
          default: event_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : event_monitor
    result_t want;
    if (!rst && event_ch.valid && event_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result transaction with no expected event");
        fail_count++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("event_code", want.event_code, event_ch.payload.event_code);
        check_field("is_pressed", want.is_pressed, event_ch.payload.is_pressed);
        check_field("early_touch", want.early_touch, event_ch.payload.early_touch);
        check_field("alt_highlight", want.alt_highlight, event_ch.payload.alt_highlight);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  int unsigned idle_cycles;

  always @(posedge clk) begin
    if (rst || (touch_ch.valid && touch_ch.ready) || (event_ch.valid && event_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("touch_button_press_classifier verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
rtl/core/tbpc_pkg.sv
rtl/core/tbpc_chan.sv
rtl/core/tbpc_regs.sv
rtl/core/tbpc_core.sv
rtl/core/touch_button_press_classifier.sv
sim/testbench.sv
